>>> rtl/ccs_pkg.sv
// Shared constants, codes and types for the circular curve element solver.
package ccs_pkg;

  localparam int LEN_W = 28;
  localparam int CRD_W = 32;
  localparam int OP_W = 3;
  localparam int IDX_W = 3;
  localparam int NUM_W = 61;
  localparam int DEN_W = 34;
  localparam int DIV_LAT = LEN_W + 1;
  localparam int N_ITER = 22;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [29:0] CORDIC_K = 30'd652032874;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [26:0] DC_CONST = 27'd112648086;

  localparam logic [OP_W-1:0] OP_DEGREE = 3'd0;
  localparam logic [OP_W-1:0] OP_RADIUS = 3'd1;
  localparam logic [OP_W-1:0] OP_TANGENT = 3'd2;
  localparam logic [OP_W-1:0] OP_EXTERNAL = 3'd3;
  localparam logic [OP_W-1:0] OP_ARC = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BACK = 2'd1;
  localparam logic [1:0] ST_AHEAD = 2'd2;
  localparam logic [1:0] ST_SAT = 2'd3;

  localparam logic [IDX_W-1:0] REG_APEX_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_APEX_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_BACK_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_BACK_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_AHEAD_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_AHEAD_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_BACK_LIM = 3'd6;
  localparam logic [IDX_W-1:0] REG_AHEAD_LIM = 3'd7;

  // sin/cos of half deflection (Q30), 1 - cos, and deflection times 2*pi (Q32)
  typedef struct packed {
    logic [30:0] s;
    logic [30:0] c;
    logic [30:0] omc;
    logic [33:0] dfl_k;
  } geo_t;

  // atan(2^-i) in 1/2^24 turn
  function automatic logic [21:0] atan_val(input logic [4:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0: v = 22'd2097152;
      5'd1: v = 22'd1238021;
      5'd2: v = 22'd654136;
      5'd3: v = 22'd332050;
      5'd4: v = 22'd166669;
      5'd5: v = 22'd83416;
      5'd6: v = 22'd41718;
      5'd7: v = 22'd20860;
      5'd8: v = 22'd10430;
      5'd9: v = 22'd5215;
      5'd10: v = 22'd2608;
      5'd11: v = 22'd1304;
      5'd12: v = 22'd652;
      5'd13: v = 22'd326;
      5'd14: v = 22'd163;
      5'd15: v = 22'd81;
      5'd16: v = 22'd41;
      5'd17: v = 22'd20;
      5'd18: v = 22'd10;
      5'd19: v = 22'd5;
      5'd20: v = 22'd3;
      5'd21: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/circular_curve_element_solver_core.sv
// Top level of the circular curve element solver: config registers and item pipeline.
//
// Each item (given element and its value) yields one result item with radius, degree of
// curve, tangent, external, arc length, status and tangent excess. The item pipeline takes
// one item per cycle while in_stall is low; its length is set by two ranks of 29-stage
// pipelined dividers (given element to radius, then radius to degree, tangent and external).
// A shared CORDIC unit derives bearings, deflection and half-angle sine/cosine from the
// configuration; it runs after reset and after every config write, and in_stall stays high
// during that time. Output stall freezes the whole pipeline.
module circular_curve_element_solver_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ccs_pkg::CRD_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ccs_pkg::OP_W-1:0]          op,
  input  logic [ccs_pkg::LEN_W-1:0]         given_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ccs_pkg::LEN_W-1:0]         radius_len,
  output logic [ccs_pkg::LEN_W-1:0]         curve_degree,
  output logic [ccs_pkg::LEN_W-1:0]         tangent_len,
  output logic [ccs_pkg::LEN_W-1:0]         external_len,
  output logic [ccs_pkg::LEN_W-1:0]         arc_len,
  output logic [1:0]                        status,
  output logic [ccs_pkg::LEN_W-1:0]         overlap_by
);

  localparam int LW = ccs_pkg::LEN_W;
  localparam int DL = ccs_pkg::DIV_LAT;

  typedef struct packed {
    logic [ccs_pkg::OP_W-1:0] op;
    logic [LW-1:0]            g;
  } head_t;

  typedef struct packed {
    logic [ccs_pkg::OP_W-1:0] op;
    logic [LW-1:0]            g;
    logic [LW-1:0]            r;
    logic                     f;
    logic [LW-1:0]            l;
    logic                     ls;
  } tail_t;

  // configuration
  logic signed [31:0] apex_x, apex_y, back_x, back_y, ahead_x, ahead_y;
  logic [LW-1:0]      back_lim, ahead_lim;
  logic               cfg_we;
  logic               geo_busy;
  ccs_pkg::geo_t      geo;

  logic hold, en;

  logic                     v0, v1, v2, v3, v4, v5;
  head_t                    h0, h1, h2, h3, h4, h5;
  logic [58:0]              gc1;
  logic [ccs_pkg::NUM_W-1:0] n2;
  logic [ccs_pkg::DEN_W-1:0] d2;
  logic [ccs_pkg::NUM_W-1:0] num1;
  logic [ccs_pkg::DEN_W-1:0] den1;

  logic [DL-1:0]            vd1, vd2;
  head_t                    hd1 [DL];
  tail_t                    td2 [DL];

  logic [LW-1:0]            q1;
  logic                     sat1;
  logic [LW-1:0]            r3, r4, r5;
  logic                     f3, f4, f5;
  logic [58:0]              prs4, pro4;
  logic [44:0]              phi4, plo4;
  logic [ccs_pkg::NUM_W-1:0] n_dc, n_t, n_e;
  logic [ccs_pkg::DEN_W-1:0] d_dc, d_c;
  logic [62:0]              lsum;
  logic [LW-1:0]            l5;
  logic                     ls5;

  logic [LW-1:0]            q_dc, q_t, q_e;
  logic                     s_dc, s_t, s_e;

  tail_t                    tl;
  logic [LW-1:0]            dc_v, t_v, e_v, l_v, ov_v;
  logic [1:0]               st_v;
  logic                     flg;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      apex_x    <= '0;
      apex_y    <= '0;
      back_x    <= '0;
      back_y    <= '0;
      ahead_x   <= '0;
      ahead_y   <= '0;
      back_lim  <= '0;
      ahead_lim <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ccs_pkg::REG_APEX_X:    apex_x    <= cfg_data;
        ccs_pkg::REG_APEX_Y:    apex_y    <= cfg_data;
        ccs_pkg::REG_BACK_X:    back_x    <= cfg_data;
        ccs_pkg::REG_BACK_Y:    back_y    <= cfg_data;
        ccs_pkg::REG_AHEAD_X:   ahead_x   <= cfg_data;
        ccs_pkg::REG_AHEAD_Y:   ahead_y   <= cfg_data;
        ccs_pkg::REG_BACK_LIM:  back_lim  <= cfg_data[LW-1:0];
        ccs_pkg::REG_AHEAD_LIM: ahead_lim <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  ccs_geo u_geo (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .apex_x  (apex_x),
    .apex_y  (apex_y),
    .back_x  (back_x),
    .back_y  (back_y),
    .ahead_x (ahead_x),
    .ahead_y (ahead_y),
    .busy    (geo_busy),
    .geo     (geo)
  );

  assign hold     = out_valid && out_stall;
  assign en       = !hold;
  assign in_stall = geo_busy || hold;

  // first divider operands by given element
  always_comb begin
    case (h1.op)
      ccs_pkg::OP_DEGREE: begin
        num1 = ccs_pkg::NUM_W'(ccs_pkg::DC_CONST);
        den1 = ccs_pkg::DEN_W'(h1.g);
      end
      ccs_pkg::OP_RADIUS: begin
        num1 = ccs_pkg::NUM_W'(h1.g);
        den1 = ccs_pkg::DEN_W'(1);
      end
      ccs_pkg::OP_TANGENT: begin
        num1 = ccs_pkg::NUM_W'(gc1);
        den1 = ccs_pkg::DEN_W'(geo.s);
      end
      ccs_pkg::OP_EXTERNAL: begin
        num1 = ccs_pkg::NUM_W'(gc1);
        den1 = ccs_pkg::DEN_W'(geo.omc);
      end
      ccs_pkg::OP_ARC: begin
        num1 = ccs_pkg::NUM_W'({h1.g, 32'd0});
        den1 = geo.dfl_k;
      end
      default: begin
        num1 = '0;
        den1 = ccs_pkg::DEN_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      vd1 <= '0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      vd2 <= '0;
    end else if (en) begin
      v0  <= in_valid && !geo_busy;
      v1  <= v0;
      v2  <= v1;
      vd1 <= {vd1[DL-2:0], v2};
      v3  <= vd1[DL-1];
      v4  <= v3;
      v5  <= v4;
      vd2 <= {vd2[DL-2:0], v5};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h0.op <= op;
      h0.g  <= given_value;

      h1  <= h0;
      gc1 <= 59'(h0.g) * 59'(geo.c);

      h2 <= h1;
      n2 <= num1 + ccs_pkg::NUM_W'(den1 >> 1);
      d2 <= den1;

      hd1[0] <= h2;
      for (int k = 1; k < DL; k++) hd1[k] <= hd1[k-1];

      h3 <= hd1[DL-1];
      r3 <= sat1 ? ccs_pkg::LEN_MAX : q1;
      f3 <= sat1;

      h4   <= h3;
      r4   <= r3;
      f4   <= f3;
      prs4 <= 59'(r3) * 59'(geo.s);
      pro4 <= 59'(r3) * 59'(geo.omc);
      phi4 <= 45'(r3) * 45'(geo.dfl_k[33:17]);
      plo4 <= 45'(r3) * 45'(geo.dfl_k[16:0]);

      h5   <= h4;
      r5   <= r4;
      f5   <= f4;
      n_dc <= ccs_pkg::NUM_W'(ccs_pkg::DC_CONST) + ccs_pkg::NUM_W'(r4 >> 1);
      d_dc <= ccs_pkg::DEN_W'(r4);
      n_t  <= ccs_pkg::NUM_W'(prs4) + ccs_pkg::NUM_W'(geo.c >> 1);
      n_e  <= ccs_pkg::NUM_W'(pro4) + ccs_pkg::NUM_W'(geo.c >> 1);
      d_c  <= ccs_pkg::DEN_W'(geo.c);
      l5   <= lsum[32+LW-1:32];
      ls5  <= lsum[62:32+LW] != '0;

      td2[0].op <= h5.op;
      td2[0].g  <= h5.g;
      td2[0].r  <= r5;
      td2[0].f  <= f5;
      td2[0].l  <= l5;
      td2[0].ls <= ls5;
      for (int k = 1; k < DL; k++) td2[k] <= td2[k-1];
    end
  end

  // arc length from radius: (R * D * 2pi + 2^31) >> 32, R*D*2pi split in two products
  assign lsum = (63'(phi4) << 17) + 63'(plo4) + 63'(64'h8000_0000);

  ccs_div u_div_r (
    .clk (clk), .en (en), .num (n2), .den (d2), .quo (q1), .sat (sat1)
  );

  ccs_div u_div_dc (
    .clk (clk), .en (en), .num (n_dc), .den (d_dc), .quo (q_dc), .sat (s_dc)
  );

  ccs_div u_div_t (
    .clk (clk), .en (en), .num (n_t), .den (d_c), .quo (q_t), .sat (s_t)
  );

  ccs_div u_div_e (
    .clk (clk), .en (en), .num (n_e), .den (d_c), .quo (q_e), .sat (s_e)
  );

  always_comb begin
    tl   = td2[DL-1];
    dc_v = (tl.op == ccs_pkg::OP_DEGREE)   ? tl.g : (s_dc  ? ccs_pkg::LEN_MAX : q_dc);
    t_v  = (tl.op == ccs_pkg::OP_TANGENT)  ? tl.g : (s_t   ? ccs_pkg::LEN_MAX : q_t);
    e_v  = (tl.op == ccs_pkg::OP_EXTERNAL) ? tl.g : (s_e   ? ccs_pkg::LEN_MAX : q_e);
    l_v  = (tl.op == ccs_pkg::OP_ARC)      ? tl.g : (tl.ls ? ccs_pkg::LEN_MAX : tl.l);
    flg  = tl.f
        || ((tl.op != ccs_pkg::OP_DEGREE)   && s_dc)
        || ((tl.op != ccs_pkg::OP_TANGENT)  && s_t)
        || ((tl.op != ccs_pkg::OP_EXTERNAL) && s_e)
        || ((tl.op != ccs_pkg::OP_ARC)      && tl.ls);
    ov_v = '0;
    if (flg) begin
      st_v = ccs_pkg::ST_SAT;
    end else if (t_v > back_lim) begin
      st_v = ccs_pkg::ST_BACK;
      ov_v = t_v - back_lim;
    end else if (t_v > ahead_lim) begin
      st_v = ccs_pkg::ST_AHEAD;
      ov_v = t_v - ahead_lim;
    end else begin
      st_v = ccs_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd2[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tl.op > ccs_pkg::OP_ARC) begin
        radius_len   <= '0;
        curve_degree <= '0;
        tangent_len  <= '0;
        external_len <= '0;
        arc_len      <= '0;
        status       <= ccs_pkg::ST_SAT;
        overlap_by   <= '0;
      end else begin
        radius_len   <= tl.r;
        curve_degree <= dc_v;
        tangent_len  <= t_v;
        external_len <= e_v;
        arc_len      <= l_v;
        status       <= st_v;
        overlap_by   <= ov_v;
      end
    end
  end

endmodule

>>> rtl/ccs_div.sv
// Pipelined restoring divider: rounded numerator in, 28-bit quotient and saturation flag out.
module ccs_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ccs_pkg::NUM_W-1:0]    num,
  input  logic [ccs_pkg::DEN_W-1:0]    den,
  output logic [ccs_pkg::LEN_W-1:0]    quo,
  output logic                         sat
);

  logic [ccs_pkg::DEN_W-1:0] rem [ccs_pkg::DIV_LAT];
  logic [ccs_pkg::LEN_W-1:0] low [ccs_pkg::DIV_LAT];
  logic [ccs_pkg::LEN_W-1:0] qb  [ccs_pkg::DIV_LAT];
  logic [ccs_pkg::DEN_W-1:0] dn  [ccs_pkg::DIV_LAT];
  logic                      sf  [ccs_pkg::DIV_LAT];

  // quotient overflows 28 bits exactly when num >> 28 >= den (den of zero included)
  always_ff @(posedge clk) begin
    if (en) begin
      sf[0]  <= {1'b0, num[ccs_pkg::NUM_W-1:ccs_pkg::LEN_W]} >= den;
      rem[0] <= {1'b0, num[ccs_pkg::NUM_W-1:ccs_pkg::LEN_W]};
      low[0] <= num[ccs_pkg::LEN_W-1:0];
      qb[0]  <= '0;
      dn[0]  <= den;
    end
  end

  for (genvar gj = 1; gj < ccs_pkg::DIV_LAT; gj++) begin : g_bit
    logic [ccs_pkg::DEN_W:0] t;
    logic [ccs_pkg::DEN_W:0] diff;
    logic                    ge;

    assign t    = {rem[gj-1], low[gj-1][ccs_pkg::LEN_W-1]};
    assign diff = t - {1'b0, dn[gj-1]};
    assign ge   = t >= {1'b0, dn[gj-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[gj] <= ge ? diff[ccs_pkg::DEN_W-1:0] : t[ccs_pkg::DEN_W-1:0];
        low[gj] <= {low[gj-1][ccs_pkg::LEN_W-2:0], 1'b0};
        qb[gj]  <= {qb[gj-1][ccs_pkg::LEN_W-2:0], ge};
        dn[gj]  <= dn[gj-1];
        sf[gj]  <= sf[gj-1];
      end
    end
  end

  assign quo = qb[ccs_pkg::DIV_LAT-1];
  assign sat = sf[ccs_pkg::DIV_LAT-1];

endmodule

>>> rtl/ccs_geo.sv
// Iterative geometry unit: bearings, deflection angle and its half-angle sine and cosine.
module ccs_geo (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  apex_x,
  input  logic signed [31:0]  apex_y,
  input  logic signed [31:0]  back_x,
  input  logic signed [31:0]  back_y,
  input  logic signed [31:0]  ahead_x,
  input  logic signed [31:0]  ahead_y,
  output logic                busy,
  output ccs_pkg::geo_t       geo
);

  localparam logic [2:0] G_IDLE  = 3'd0;
  localparam logic [2:0] G_LOAD  = 3'd1;
  localparam logic [2:0] G_NORM  = 3'd2;
  localparam logic [2:0] G_SHIFT = 3'd3;
  localparam logic [2:0] G_VEC   = 3'd4;
  localparam logic [2:0] G_ROT0  = 3'd5;
  localparam logic [2:0] G_ROT   = 3'd6;
  localparam logic [2:0] G_FIN   = 3'd7;
  localparam logic [4:0] LAST_IT = 5'(ccs_pkg::N_ITER - 1);

  function automatic logic [32:0] mag(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  // left shift that brings the larger magnitude up to bit 39
  function automatic logic [5:0] lead_shift(input logic [32:0] m);
    logic [5:0] pos;
    pos = '0;
    for (int p = 0; p < 33; p++) begin
      if (m[p]) pos = 6'(p);
    end
    return 6'd39 - pos;
  endfunction

  logic [2:0]          state;
  logic [4:0]          i;
  logic signed [32:0]  dx_b, dy_b, dx_a, dy_a;
  logic [5:0]          k_b, k_a;
  logic                zero_b, zero_a;
  logic signed [43:0]  xb, yb, xa, ya;
  logic signed [25:0]  angb, anga;
  logic [15:0]         dfl;
  logic signed [33:0]  rx, ry;
  logic signed [25:0]  rz;

  logic signed [43:0]  xs_b, ys_b, xs_a, ys_a;
  logic signed [43:0]  xb_next, yb_next, xa_next, ya_next;
  logic signed [25:0]  angb_next, anga_next, rz_next, at;
  logic signed [33:0]  rx_next, ry_next;
  logic [24:0]         bsum_b, bsum_a;
  logic [15:0]         bear_b, bear_a, inc, inc_f, dfl_next;
  logic [30:0]         c_next, s_next;

  assign busy = state != G_IDLE;

  always_comb begin
    at   = signed'(26'(ccs_pkg::atan_val(i)));
    xs_b = 44'(dx_b) <<< k_b;
    ys_b = 44'(dy_b) <<< k_b;
    xs_a = 44'(dx_a) <<< k_a;
    ys_a = 44'(dy_a) <<< k_a;

    if (!yb[43]) begin
      xb_next   = xb + (yb >>> i);
      yb_next   = yb - (xb >>> i);
      angb_next = angb + at;
    end else begin
      xb_next   = xb - (yb >>> i);
      yb_next   = yb + (xb >>> i);
      angb_next = angb - at;
    end
    if (!ya[43]) begin
      xa_next   = xa + (ya >>> i);
      ya_next   = ya - (xa >>> i);
      anga_next = anga + at;
    end else begin
      xa_next   = xa - (ya >>> i);
      ya_next   = ya + (xa >>> i);
      anga_next = anga - at;
    end

    if (!rz[25]) begin
      rx_next = rx - (ry >>> i);
      ry_next = ry + (rx >>> i);
      rz_next = rz - at;
    end else begin
      rx_next = rx + (ry >>> i);
      ry_next = ry - (rx >>> i);
      rz_next = rz + at;
    end

    bsum_b = {1'b0, angb[23:0]} + 25'd128;
    bsum_a = {1'b0, anga[23:0]} + 25'd128;
    bear_b = zero_b ? '0 : bsum_b[23:8];
    bear_a = zero_a ? '0 : bsum_a[23:8];
    inc    = bear_b - bear_a;
    inc_f  = (inc > 16'd32768) ? (16'd0 - inc) : inc;
    dfl_next = 16'd32768 - inc_f;

    if (rx[33])                        c_next = '0;
    else if (rx > 34'sd1073741824)     c_next = ccs_pkg::ONE_Q30;
    else                               c_next = rx[30:0];
    if (ry[33])                        s_next = '0;
    else if (ry > 34'sd1073741824)     s_next = ccs_pkg::ONE_Q30;
    else                               s_next = ry[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_LOAD;
      i     <= '0;
    end else if (start) begin
      state <= G_LOAD;
      i     <= '0;
    end else begin
      case (state)
        G_IDLE:  state <= G_IDLE;
        G_LOAD:  state <= G_NORM;
        G_NORM:  state <= G_SHIFT;
        G_SHIFT: begin
          state <= G_VEC;
          i     <= '0;
        end
        G_VEC: begin
          if (i == LAST_IT) state <= G_ROT0;
          else i <= i + 5'd1;
        end
        G_ROT0: begin
          state <= G_ROT;
          i     <= '0;
        end
        G_ROT: begin
          if (i == LAST_IT) state <= G_FIN;
          else i <= i + 5'd1;
        end
        G_FIN:   state <= G_IDLE;
        default: state <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      G_LOAD: begin
        dx_b <= 33'(back_x) - 33'(apex_x);
        dy_b <= 33'(back_y) - 33'(apex_y);
        dx_a <= 33'(ahead_x) - 33'(apex_x);
        dy_a <= 33'(ahead_y) - 33'(apex_y);
      end
      G_NORM: begin
        k_b    <= lead_shift(mag(dx_b) | mag(dy_b));
        k_a    <= lead_shift(mag(dx_a) | mag(dy_a));
        zero_b <= (dx_b == '0) && (dy_b == '0);
        zero_a <= (dx_a == '0) && (dy_a == '0);
      end
      G_SHIFT: begin
        // left half-plane: rotate by a half turn first
        if (xs_b[43]) begin
          xb   <= -xs_b;
          yb   <= -ys_b;
          angb <= 26'sd8388608;
        end else begin
          xb   <= xs_b;
          yb   <= ys_b;
          angb <= '0;
        end
        if (xs_a[43]) begin
          xa   <= -xs_a;
          ya   <= -ys_a;
          anga <= 26'sd8388608;
        end else begin
          xa   <= xs_a;
          ya   <= ys_a;
          anga <= '0;
        end
      end
      G_VEC: begin
        xb   <= xb_next;
        yb   <= yb_next;
        angb <= angb_next;
        xa   <= xa_next;
        ya   <= ya_next;
        anga <= anga_next;
      end
      G_ROT0: begin
        dfl <= dfl_next;
        rx  <= signed'(34'(ccs_pkg::CORDIC_K));
        ry  <= '0;
        rz  <= signed'(26'({dfl_next, 7'd0}));
      end
      G_ROT: begin
        rx <= rx_next;
        ry <= ry_next;
        rz <= rz_next;
      end
      G_FIN: begin
        geo.c     <= c_next;
        geo.s     <= s_next;
        geo.omc   <= ccs_pkg::ONE_Q30 - c_next;
        geo.dfl_k <= 34'(dfl) * 34'(ccs_pkg::TWO_PI_Q16);
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/ccs_checker.sv
// Port-level checks for the circular curve element solver, bound to the top level.
module ccs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                status,
  input logic [ccs_pkg::LEN_W-1:0] radius_len,
  input logic [ccs_pkg::LEN_W-1:0] overlap_by
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(radius_len))
    else $error("result item changed while stalled");

  a_no_excess: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ccs_pkg::ST_OK || status == ccs_pkg::ST_SAT) |-> overlap_by == '0)
    else $error("tangent excess reported without overlap status");

  a_excess: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ccs_pkg::ST_BACK || status == ccs_pkg::ST_AHEAD)
      |-> overlap_by != '0)
    else $error("overlap status with zero excess");

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> in_stall)
    else $error("input taken while geometry is recomputed");

endmodule

bind circular_curve_element_solver_core ccs_checker u_ccs_checker (.*);

>>> tb/tb_circular_curve_element_solver_core.sv
// Testbench for the circular curve element solver: predicts and checks every result item.
module tb_circular_curve_element_solver_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ccs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 120;
  localparam longint unsigned SAT_LEN = 64'd268435455;
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned ARC_K = 64'd411775;
  localparam longint unsigned DEG_K = 64'd112648086;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam int ROT_STEPS = 22;
  localparam longint ATAN_TURN [ROT_STEPS] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  typedef struct {
    logic [LEN_W-1:0] f [7];
  } curve_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid, cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CRD_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [OP_W-1:0] op;
  logic [LEN_W-1:0] given_value;
  logic out_valid, out_stall;
  logic [LEN_W-1:0] radius_len, curve_degree, tangent_len, external_len, arc_len, overlap_by;
  logic [1:0] status;

  // geometry mirror, indexed by register
  logic [CRD_W-1:0] geo_reg [8];
  curve_t curve_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit rx_hold = 0;
  bit no_idle = 0;
  string field_name [7] = '{"radius_len", "curve_degree", "tangent_len", "external_len",
                            "arc_len", "status", "overlap_by"};

  circular_curve_element_solver_core i_dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned bearing16(longint x, longint y);
    longint ang, nx, ny;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    while ((x < 0 ? -x : x) < (64'sd1 << 39) && (y < 0 ? -y : y) < (64'sd1 << 39)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 64'sd1 << 23;
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        ang += ATAN_TURN[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        ang -= ATAN_TURN[i];
      end
      x = nx;
      y = ny;
    end
    return (((ang & 64'hFFFFFF) + 128) >> 8) & 64'hFFFF;
  endfunction

  function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den,
                                           inout bit sat);
    longint unsigned q;
    if (den == 0) begin
      sat = 1;
      return SAT_LEN;
    end
    q = (num + den / 2) / den;
    if (q > SAT_LEN) begin
      sat = 1;
      return SAT_LEN;
    end
    return q;
  endfunction

  function automatic curve_t solve_curve(logic [OP_W-1:0] kind, logic [LEN_W-1:0] val);
    curve_t r;
    longint ax, ay, x, y, z, nx, ny;
    longint unsigned b_back, b_ahead, inc, dfl, s, c, g, rad, deg, tan_l, ext, arc, over;
    longint unsigned blim, alim;
    bit sat;
    logic [1:0] st;
    sat = 0;
    over = 0;
    st = ST_OK;
    g = 64'(val);
    if (kind > OP_ARC) begin
      foreach (r.f[i]) r.f[i] = '0;
      r.f[5] = LEN_W'(ST_SAT);
      return r;
    end
    ax = longint'($signed(geo_reg[REG_APEX_X]));
    ay = longint'($signed(geo_reg[REG_APEX_Y]));
    b_back = bearing16(longint'($signed(geo_reg[REG_BACK_X])) - ax,
                       longint'($signed(geo_reg[REG_BACK_Y])) - ay);
    b_ahead = bearing16(longint'($signed(geo_reg[REG_AHEAD_X])) - ax,
                        longint'($signed(geo_reg[REG_AHEAD_Y])) - ay);
    inc = (b_back - b_ahead) & 64'hFFFF;
    if (inc > 32768) inc = 65536 - inc;
    dfl = 32768 - inc;
    // rotate the gain-compensated unit vector by half the deflection
    x = GAIN_Q30;
    y = 0;
    z = longint'(dfl << 7);
    for (int i = 0; i < ROT_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN_TURN[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN_TURN[i];
      end
      x = nx;
      y = ny;
    end
    if (x < 0) x = 0;
    if (x > longint'(Q30_ONE)) x = Q30_ONE;
    if (y < 0) y = 0;
    if (y > longint'(Q30_ONE)) y = Q30_ONE;
    c = x;
    s = y;
    case (kind)
      OP_DEGREE: rad = rdiv(DEG_K, g, sat);
      OP_RADIUS: rad = g;
      OP_TANGENT: rad = rdiv(g * c, s, sat);
      OP_EXTERNAL: rad = rdiv(g * c, Q30_ONE - c, sat);
      default: rad = rdiv(g << 32, dfl * ARC_K, sat);
    endcase
    deg = (kind == OP_DEGREE) ? g : rdiv(DEG_K, rad, sat);
    tan_l = (kind == OP_TANGENT) ? g : rdiv(rad * s, c, sat);
    ext = (kind == OP_EXTERNAL) ? g : rdiv(rad * (Q30_ONE - c), c, sat);
    if (kind == OP_ARC) begin
      arc = g;
    end else begin
      arc = (rad * dfl * ARC_K + (64'd1 << 31)) >> 32;
      if (arc > SAT_LEN) begin
        arc = SAT_LEN;
        sat = 1;
      end
    end
    blim = 64'(geo_reg[REG_BACK_LIM][LEN_W-1:0]);
    alim = 64'(geo_reg[REG_AHEAD_LIM][LEN_W-1:0]);
    if (sat) begin
      st = ST_SAT;
    end else if (tan_l > blim) begin
      st = ST_BACK;
      over = tan_l - blim;
    end else if (tan_l > alim) begin
      st = ST_AHEAD;
      over = tan_l - alim;
    end
    r.f[0] = rad[LEN_W-1:0];
    r.f[1] = deg[LEN_W-1:0];
    r.f[2] = tan_l[LEN_W-1:0];
    r.f[3] = ext[LEN_W-1:0];
    r.f[4] = arc[LEN_W-1:0];
    r.f[5] = LEN_W'(st);
    r.f[6] = over[LEN_W-1:0];
    return r;
  endfunction

  // prediction on input, checking on output, watchdog on neither
  always @(posedge clk) begin
    curve_t want;
    logic [LEN_W-1:0] got [7];
    if (!rst) begin
      if (in_valid && !in_stall) curve_q.push_back(solve_curve(op, given_value));
      if (out_valid && !out_stall) begin
        got = '{radius_len, curve_degree, tangent_len, external_len, arc_len,
                LEN_W'(status), overlap_by};
        if (curve_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item, radius_len %0d", $time, radius_len);
        end else begin
          want = curve_q.pop_front();
          foreach (got[i])
            if (got[i] !== want.f[i]) begin
              errors++;
              $display("%0t: %s expected %0d actual %0d", $time, field_name[i],
                       want.f[i], got[i]);
            end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int k;
    out_stall <= 1'b0;
    forever begin
      k = $urandom_range(0, 9);
      if (rx_hold) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 0;
      end else if (no_idle || k < 6) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (k < 9 ? $urandom_range(1, 3) : $urandom_range(5, 25)) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic [OP_W-1:0] kind, logic [LEN_W-1:0] val);
    int k, gap;
    k = $urandom_range(0, 9);
    gap = (no_idle || k < 6) ? 0 : (k < 9 ? $urandom_range(1, 3) : $urandom_range(5, 30));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= kind;
    given_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (curve_q.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high so that writes can follow back to back
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CRD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    geo_reg[idx] = (idx >= REG_BACK_LIM) ? {4'd0, val[LEN_W-1:0]} : val;
  endtask

  task automatic set_geometry(logic [CRD_W-1:0] v [8]);
    drain_results();
    foreach (v[i]) write_reg(IDX_W'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [LEN_W-1:0] pick_value();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return LEN_W'($urandom_range(0, 2));
    if (k == 1) return LEN_MAX - LEN_W'($urandom_range(0, 2));
    if (k < 5) return LEN_W'($urandom);
    return LEN_W'($urandom_range(256, 1 << 20));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    return ($urandom_range(0, 19) == 0) ? OP_W'($urandom_range(5, 7))
                                        : OP_W'($urandom_range(0, 4));
  endfunction

  task automatic test_directed();
    logic [CRD_W-1:0] v [8];
    // all points at the apex: deflection is a half turn
    send_item(OP_RADIUS, 28'd25600);
    send_item(OP_ARC, 28'd25600);
    // 45 degree turn, back on the -x axis
    v = '{0, 0, -32'sd25600, 0, 32'd25600, 32'd25600, 32'd40000, 32'd20000};
    set_geometry(v);
    for (int k = 0; k < 5; k++) begin
      send_item(OP_W'(k), 28'd0);
      send_item(OP_W'(k), LEN_MAX);
      send_item(OP_W'(k), 28'd51200);
    end
    for (int k = 5; k < 8; k++) send_item(OP_W'(k), 28'd12345);
    // straight line: zero deflection
    v = '{0, 0, -32'sd25600, 0, 32'd25600, 0, 32'd0, CRD_W'(LEN_MAX)};
    set_geometry(v);
    send_item(OP_TANGENT, 28'd2560);
    send_item(OP_EXTERNAL, 28'd2560);
    send_item(OP_ARC, 28'd2560);
    send_item(OP_RADIUS, 28'd2560);
  endtask

  task automatic test_config_extremes();
    logic [CRD_W-1:0] v [8];
    v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000};
    set_geometry(v);
    for (int k = 0; k < 10; k++) send_item(pick_op(), pick_value());
  endtask

  task automatic random_phase(int n, bit wild);
    logic [CRD_W-1:0] v [8];
    logic [CRD_W-1:0] ax, ay;
    ax = CRD_W'($urandom_range(0, 1 << 25)) - (1 << 24);
    ay = CRD_W'($urandom_range(0, 1 << 25)) - (1 << 24);
    v[REG_APEX_X] = ax;
    v[REG_APEX_Y] = ay;
    for (int i = REG_BACK_X; i <= REG_AHEAD_Y; i++)
      v[i] = (i[0] ? ay : ax) + CRD_W'($urandom_range(0, 1 << 17)) - (1 << 16);
    v[REG_BACK_LIM] = $urandom_range(0, 1 << 22);
    v[REG_AHEAD_LIM] = $urandom_range(0, 1 << 22);
    if (wild) foreach (v[i]) v[i] = $urandom;
    set_geometry(v);
    for (int k = 0; k < n; k++) send_item(pick_op(), pick_value());
  endtask

  task automatic test_backpressure();
    rx_hold = 1;
    for (int k = 0; k < 100; k++) send_item(pick_op(), pick_value());
  endtask

  task automatic test_no_idle();
    no_idle = 1;
    for (int k = 0; k < 60; k++) send_item(pick_op(), pick_value());
    drain_results();
    no_idle = 0;
  endtask

  initial begin
    foreach (geo_reg[i]) geo_reg[i] = '0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    op <= '0;
    given_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    for (int p = 0; p < 5; p++) random_phase(110, p == 4);
    test_backpressure();
    test_no_idle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
